// ----- hdl/sha_pkg.sv -----
// Shared types and constants for the SHA-256 message digest block.
package sha_pkg;

  localparam int unsigned WordW = 32;

  // Queue entry between the front end and the compression engine.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             blk_end;  // word completes a 16-word block
    logic             msg_end;  // block is the last one of the message
  } sha_word_t;

  function automatic logic [WordW-1:0] round_k(input logic [5:0] idx);
    logic [WordW-1:0] k;
    begin
      case (idx)
        6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [WordW-1:0] init_hash(input logic [2:0] idx);
    logic [WordW-1:0] h;
    begin
      case (idx)
        3'd0: h = 32'h6a09e667;
        3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372;
        3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f;
        3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab;
        default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  localparam logic [7:0] PadByte = 8'h80;

endpackage

// ----- hdl/sha_front.sv -----
// Front end: counts message bits, masks the tail and emits padded schedule words.
module sha_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       in_word_i,
  input  logic [2:0]        in_bytes_i,
  input  logic              in_last_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output sha_pkg::sha_word_t q_data_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StPadWord, StZero, StLenHi, StLenLo
  } front_state_e;

  front_state_e state_q;
  logic [3:0]   cnt_q;
  logic [63:0]  bits_q;
  logic [2:0]   nb;
  logic [31:0]  keep, padw, word;
  logic [63:0]  bits_sum;

  always_comb begin
    nb = (in_bytes_i > 3'd4) ? 3'd4 : in_bytes_i;
    case (nb)
      3'd0: begin keep = 32'h0; padw = {PadByte, 24'h0}; end
      3'd1: begin keep = 32'hff000000; padw = {8'h0, PadByte, 16'h0}; end
      3'd2: begin keep = 32'hffff0000; padw = {16'h0, PadByte, 8'h0}; end
      3'd3: begin keep = 32'hffffff00; padw = {24'h0, PadByte}; end
      default: begin keep = 32'hffffffff; padw = 32'h0; end
    endcase
    bits_sum = bits_q + (in_last_i ? {58'd0, nb, 3'd0} : 64'd32);
    case (state_q)
      StIdle:    word = in_last_i ? ((in_word_i & keep) | padw) : in_word_i;
      StPadWord: word = {PadByte, 24'h0};
      StLenHi:   word = bits_q[63:32];
      StLenLo:   word = bits_q[31:0];
      default:   word = 32'h0;
    endcase
  end

  assign in_ready_o = (state_q == StIdle) && q_ready_i;
  assign q_valid_o  = (state_q != StIdle) || in_valid_i;
  assign q_data_o   = '{word: word, blk_end: (cnt_q == 4'd15),
                        msg_end: (state_q == StLenLo)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      bits_q  <= '0;
    end else if (q_valid_o && q_ready_i) begin
      cnt_q <= cnt_q + 4'd1;
      case (state_q)
        StIdle: begin
          bits_q <= bits_sum;
          if (in_last_i) begin
            if (nb == 3'd4) state_q <= StPadWord;
            else if (cnt_q == 4'd13) state_q <= StLenHi;
            else state_q <= StZero;
          end
        end
        StPadWord, StZero: begin
          if (cnt_q == 4'd13) state_q <= StLenHi;
          else state_q <= StZero;
        end
        StLenHi: state_q <= StLenLo;
        StLenLo: begin
          state_q <= StIdle;
          bits_q  <= '0;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- hdl/sha_fifo.sv -----
// Short request queue between front end and compression engine.
module sha_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  sha_pkg::sha_word_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output sha_pkg::sha_word_t rd_data_o
);
  import sha_pkg::*;

  sha_word_t  mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 3'd4;
  assign rd_valid_o = cnt_q != 3'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
    end
  end

endmodule

// ----- hdl/sha_core.sv -----
// Compression engine: loads 16 words, runs 64 rounds, emits the digest.
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  sha_pkg::sha_word_t q_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_word_o,
  output logic [2:0]         out_pos_o,
  output logic               out_end_o
);
  import sha_pkg::*;

  typedef enum logic [1:0] { StLoad, StRound, StFinish, StEmit } core_state_e;

  core_state_e state_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  rnd_q;
  logic [2:0]  pos_q;
  logic        last_q;
  logic [31:0] wn, s0, s1, wr_cur, t1, t2, e, a, ch, maj, se, sa;

  assign q_ready_o   = state_q == StLoad;
  assign out_valid_o = state_q == StEmit;
  assign out_word_o  = h_q[pos_q];
  assign out_pos_o   = pos_q;
  assign out_end_o   = pos_q == 3'd7;

  always_comb begin
    s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    wr_cur = w_q[0];
    e  = v_q[4];
    a  = v_q[0];
    se = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    sa = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    ch  = (e & v_q[5]) ^ (~e & v_q[6]);
    maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + se + ch + round_k(rnd_q) + wr_cur;
    t2 = sa + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      rnd_q   <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_hash(3'(i));
        v_q[i] <= '0;
      end
    end else begin
      case (state_q)
        StLoad: begin
          if (q_valid_i) begin
            // shift the new word in at the top of the window
            for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
            w_q[15] <= q_data_i.word;
            if (q_data_i.blk_end) begin
              last_q  <= q_data_i.msg_end;
              state_q <= StRound;
              rnd_q   <= '0;
              for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            end
          end
        end
        StRound: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wn;
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= StFinish;
        end
        StFinish: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          pos_q   <= '0;
          state_q <= last_q ? StEmit : StLoad;
        end
        StEmit: begin
          if (out_ready_i) begin
            pos_q <= pos_q + 3'd1;
            if (pos_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
              state_q <= StLoad;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

endmodule

// ----- hdl/sha256_message_digest.sv -----
// Top level of the SHA-256 message digest block.
// Input stream: one big-endian message word per request; tuser carries the
// count of valid leading bytes (0..4, above 4 counts as 4, used only with
// tlast), tlast marks the final word. Output stream: eight digest words,
// tuser the word position, tlast on the eighth word.
// A front end pads and counts bits and feeds a four-entry queue; the
// compression engine loads 16 words, then runs one round per cycle.
// Per block the engine loads 16 words, runs 64 rounds, then a finish step;
// it takes no new word until that block is done. The digest follows the
// last padded block. A stall on the output holds the digest; the engine and,
// once the queue is full, the input stall with it. Reset loads the initial
// hash values and clears the bit count; no request is in flight afterwards.
module sha256_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // message_word
  input  logic [2:0]  s_axis_tuser,   // valid_bytes
  input  logic        s_axis_tlast,   // final_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_position
  output logic        m_axis_tlast    // digest_end
);
  import sha_pkg::*;

  logic      f_valid, f_ready, c_valid, c_ready;
  sha_word_t f_data, c_data;

  sha_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_word_i(s_axis_tdata), .in_bytes_i(s_axis_tuser), .in_last_i(s_axis_tlast),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_data_o(f_data)
  );

  sha_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(c_valid), .rd_ready_i(c_ready), .rd_data_o(c_data)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .q_valid_i(c_valid), .q_ready_o(c_ready), .q_data_i(c_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(m_axis_tdata), .out_pos_o(m_axis_tuser), .out_end_o(m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("digest end flag out of step with position");
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest words not consecutive");
  a_no_load_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(c_ready && m_axis_tvalid))
    else $error("engine loads while emitting");
`endif

endmodule

// ----- verif/sha256_digest_checker.sv -----
// Checker for the SHA-256 digest block: predicts digests and compares them.
`timescale 1ns / 1ps
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          digests_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [7:0] PadMark = 8'h80;

  logic [31:0]  chain [8];
  logic [31:0]  block_words [16];
  int unsigned  fill;
  logic [63:0]  bit_count;
  digest_word_t expected_digest_q[$];
  int           fails;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int r = 0; r < 16; r++) w[r] = block_words[r];
    for (int r = 16; r < 64; r++) begin
      s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    v = chain;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic load_word(input logic [31:0] w);
    block_words[fill] = w;
    fill = (fill + 1) % 16;
    if (fill == 0) compress();
  endtask

  task automatic absorb_request(input logic [31:0] data, input logic [2:0] nbytes_in,
                                input logic is_last);
    int unsigned nb;
    logic [31:0] keep, w;
    digest_word_t d;
    if (!is_last) begin
      bit_count += 32;
      load_word(data);
      return;
    end
    nb = (nbytes_in > 4) ? 4 : nbytes_in;
    bit_count += nb * 8;
    keep = (nb == 0) ? 32'h0 : ~(32'hffffffff >> (nb * 8));
    w = data & keep;
    if (nb < 4) w |= {24'h0, PadMark} << (8 * (3 - nb));
    load_word(w);
    if (nb == 4) load_word({PadMark, 24'h0});
    while (fill != 14) load_word(32'h0);
    load_word(bit_count[63:32]);
    load_word(bit_count[31:0]);
    for (int k = 0; k < 8; k++) begin
      d.word = chain[k];
      d.pos = 3'(k);
      d.last = (k == 7);
      expected_digest_q.push_back(d);
    end
    chain = InitHash;
    bit_count = '0;
    fill = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_w;
    if (!rst_ni) begin
      chain = InitHash;
      fill = 0;
      bit_count = '0;
      expected_digest_q.delete();
      fails = 0;
      digests_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        absorb_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digest_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected digest word %h", m_axis_tdata);
        end else begin
          exp_w = expected_digest_q.pop_front();
          if (exp_w != {m_axis_tdata, m_axis_tuser, m_axis_tlast}) begin
            fails++;
            if (fails <= 10)
              $display("digest mismatch: exp %h pos %0d end %b, got %h pos %0d end %b",
                       exp_w.word, exp_w.pos, exp_w.last,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
          if (m_axis_tlast) digests_o <= digests_o + 1;
        end
      end
    end
    fail_count_o = fails;
    pending_o = expected_digest_q.size();
  end

endmodule

// ----- verif/sha256_message_digest_tb.sv -----
// Testbench top: drives message streams into the digest block and gives the verdict.
`timescale 1ns / 1ps
module sha256_message_digest_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count, pending, digests;
  int          burst_left = 0;
  bit          hold_off = 1'b0;
  int          sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sha256_message_digest u_dut (.*);

  sha256_digest_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .m_axis_tlast, .fail_count_o(fail_count), .pending_o(pending), .digests_o(digests));

  // Receiver: stall in its own pattern, or hold off entirely when asked.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (burst_left > 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end
  always @(posedge clk_i) begin
    if (burst_left > 0) burst_left <= burst_left - 1;
    else if ($urandom_range(0, 40) == 0) burst_left <= $urandom_range(20, 200);
  end

  // Offer one request and hold it until accepted.
  task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= nb;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_message(input int nwords, input logic [2:0] nb, input bit gaps);
    for (int i = 0; i < nwords; i++) begin
      send_word($urandom(), (i == nwords - 1) ? nb : 3'($urandom()), i == nwords - 1);
      if (gaps) idle_gap();
    end
  endtask

  // Let the last accepted request reach the checker before looking at the count.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, each tail length, over-range count, length overlap.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'h00000000, 3'd5, 1'b1);
    send_message(14, 3'd4, 1'b0);
    send_message(14, 3'd2, 1'b0);
    drain();
    // Receiver holds off while the sender keeps offering two more messages.
    hold_off <= 1'b1;
    fork
      begin
        send_message(40, 3'd3, 1'b0);
        send_message(16, 3'd1, 1'b0);
      end
      begin
        repeat (1500) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join
    drain();
    // Random messages in bursts, most short, a few crossing block borders.
    while (sent < 116) begin
      send_message(($urandom_range(0, 5) == 0) ? $urandom_range(13, 34)
                                               : $urandom_range(1, 8),
                   3'($urandom()), 1'b1);
      if ($urandom_range(0, 6) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d requests and %0d digests, tails of every length", sent, digests);
    $display("including the length overlap case and a long output stall");
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sha_pkg.sv
hdl/sha_front.sv
hdl/sha_fifo.sv
hdl/sha_core.sv
hdl/sha256_message_digest.sv
verif/sha256_digest_checker.sv
verif/sha256_message_digest_tb.sv
